// ===== rtl/ladrc_pkg.sv =====
// shared types, constants, saturating helpers and the sequencer program of the adrc block
`default_nettype none
package ladrc_pkg;

	// word format, fixed by the 32 bit fields at the ports
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int MAG_W     = 2 * WORD_BITS + 1;
	localparam int DIV_STEPS = WORD_BITS + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int H_BITS    = WORD_BITS - 1;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic [WORD_BITS-1:0]        umag_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANT_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BETA_THREE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_TIME = 3'd4;

	localparam word_t RST_PLANT_GAIN = 32'sd65536;
	localparam word_t RST_BETA_ONE   = 32'sd65536;
	localparam word_t RST_BETA_TWO   = 32'sd6554;
	localparam word_t RST_BETA_THREE = 32'sd656;
	localparam logic [H_BITS-1:0] RST_SAMPLE_TIME = 31'd655;

	// beat payloads
	typedef struct packed {
		logic signed [31:0] target_value;
		logic signed [31:0] measured_value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] control_value;
		logic signed [31:0] tracking_error;
		logic signed [31:0] position_estimate;
		logic signed [31:0] rate_estimate;
		logic signed [31:0] disturbance_estimate;
		logic               divide_fault;
	} out_item_t;

	// micro operations
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// operand sources
	localparam logic [3:0] SRC_Z1   = 4'd0;
	localparam logic [3:0] SRC_Z2   = 4'd1;
	localparam logic [3:0] SRC_Z3   = 4'd2;
	localparam logic [3:0] SRC_U    = 4'd3;
	localparam logic [3:0] SRC_E1   = 4'd4;
	localparam logic [3:0] SRC_ERR  = 4'd5;
	localparam logic [3:0] SRC_T    = 4'd6;
	localparam logic [3:0] SRC_NZ2  = 4'd7;
	localparam logic [3:0] SRC_R    = 4'd8;
	localparam logic [3:0] SRC_Y    = 4'd9;
	localparam logic [3:0] SRC_B1   = 4'd10;
	localparam logic [3:0] SRC_B2   = 4'd11;
	localparam logic [3:0] SRC_B3   = 4'd12;
	localparam logic [3:0] SRC_H    = 4'd13;
	localparam logic [3:0] SRC_ZERO = 4'd14;
	localparam logic [3:0] SRC_B0   = 4'd15;

	// scratch destinations
	localparam logic [2:0] DST_E1  = 3'd0;
	localparam logic [2:0] DST_ERR = 3'd1;
	localparam logic [2:0] DST_T   = 3'd2;
	localparam logic [2:0] DST_NZ1 = 3'd3;
	localparam logic [2:0] DST_NZ2 = 3'd4;
	localparam logic [2:0] DST_NZ3 = 3'd5;
	localparam logic [2:0] DST_NU  = 3'd6;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] a_sel;
		logic [3:0] b_sel;
		logic [2:0] dst;
	} uop_t;

	localparam int PROG_LEN = 18;
	localparam int PC_W     = $clog2(PROG_LEN);
	localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LEN - 1);

	// controller to datapath
	typedef struct packed {
		logic load;
		logic issue;
		logic mul_wb;
		logic commit;
		uop_t uop;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

	// observer update, error and control law, one operation per entry
	function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T};
		unique case (pc)
			5'd0:  u = '{OP_SUB, SRC_Z1,   SRC_Y,   DST_E1};
			5'd1:  u = '{OP_SUB, SRC_R,    SRC_Y,   DST_ERR};
			5'd2:  u = '{OP_MUL, SRC_B1,   SRC_E1,  DST_T};
			5'd3:  u = '{OP_SUB, SRC_Z2,   SRC_T,   DST_T};
			5'd4:  u = '{OP_MUL, SRC_H,    SRC_T,   DST_T};
			5'd5:  u = '{OP_ADD, SRC_Z1,   SRC_T,   DST_NZ1};
			5'd6:  u = '{OP_MUL, SRC_B2,   SRC_E1,  DST_T};
			5'd7:  u = '{OP_SUB, SRC_Z3,   SRC_T,   DST_T};
			5'd8:  u = '{OP_ADD, SRC_T,    SRC_U,   DST_T};
			5'd9:  u = '{OP_MUL, SRC_H,    SRC_T,   DST_T};
			5'd10: u = '{OP_ADD, SRC_Z2,   SRC_T,   DST_NZ2};
			5'd11: u = '{OP_MUL, SRC_B3,   SRC_E1,  DST_T};
			5'd12: u = '{OP_SUB, SRC_ZERO, SRC_T,   DST_T};
			5'd13: u = '{OP_MUL, SRC_H,    SRC_T,   DST_T};
			5'd14: u = '{OP_ADD, SRC_Z3,   SRC_T,   DST_NZ3};
			5'd15: u = '{OP_MUL, SRC_B1,   SRC_ERR, DST_T};
			5'd16: u = '{OP_SUB, SRC_T,    SRC_NZ2, DST_T};
			5'd17: u = '{OP_DIV, SRC_T,    SRC_B0,  DST_NU};
			default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T};
		endcase
		return u;
	endfunction

	// magnitude of a signed word, exact for the most negative value
	function automatic umag_t mag(input word_t a);
		umag_t m;
		m = a[WORD_BITS-1] ? umag_t'(-a) : umag_t'(a);
		return m;
	endfunction

	// signed word from a magnitude and a sign, clamped to the word range
	function automatic word_t sat_mag(input logic [MAG_W-1:0] m, input logic neg);
		logic [MAG_W-1:0] lim;
		logic [MAG_W-1:0] c;
		logic [WORD_BITS-1:0] lo;
		lim = neg ? (MAG_W'(1) << (WORD_BITS - 1))
			: ((MAG_W'(1) << (WORD_BITS - 1)) - MAG_W'(1));
		c   = (m > lim) ? lim : m;
		lo  = c[WORD_BITS-1:0];
		return neg ? word_t'(-lo) : word_t'(lo);
	endfunction

	// saturating add or subtract
	function automatic word_t sat_addsub(input word_t a, input word_t b, input logic sub);
		logic [WORD_BITS:0] s;
		s = sub ? ({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b})
			: ({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
		if (s[WORD_BITS] != s[WORD_BITS-1]) begin
			return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
		end
		return word_t'(s[WORD_BITS-1:0]);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ladrc_ctrl.sv =====
// sequencer for the adrc datapath: steps through the operation program once per sample
`default_nettype none
module ladrc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ladrc_pkg::status_t status,
	output ladrc_pkg::cmd_t        cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_MULWB = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]                 state_q;
	logic [2:0]                 state_d;
	logic [ladrc_pkg::PC_W-1:0] pc_q;
	logic [ladrc_pkg::PC_W-1:0] pc_d;
	ladrc_pkg::uop_t            uop;

	assign uop      = ladrc_pkg::uop_at(pc_q);
	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d    = state_q;
		pc_d       = pc_q;
		cmd        = '0;
		cmd.uop    = uop;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pc_d     = '0;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.issue = 1'b1;
				priority if (uop.op == ladrc_pkg::OP_MUL) begin
					state_d = S_MULWB;
				end else if (uop.op == ladrc_pkg::OP_DIV) begin
					state_d = S_DIV;
				end else if (pc_q == ladrc_pkg::PC_LAST) begin
					state_d = S_FIN;
				end else begin
					pc_d = pc_q + 1'b1;
				end
			end
			S_MULWB: begin
				cmd.mul_wb = 1'b1;
				pc_d       = pc_q + 1'b1;
				state_d    = S_EXEC;
			end
			S_DIV: begin
				if (status.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ladrc_datapath.sv =====
// adrc datapath: config registers, observer state, saturating alu, multiplier, divider, output
`default_nettype none
module ladrc_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ladrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ladrc_pkg::WORD_BITS-1:0]   cfg_data,
	input  wire ladrc_pkg::in_item_t               in_data,
	input  wire ladrc_pkg::cmd_t                   cmd,
	output ladrc_pkg::status_t                     status,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output ladrc_pkg::out_item_t                   out_data
);

	localparam int W  = ladrc_pkg::WORD_BITS;
	localparam int F  = ladrc_pkg::FRAC_BITS;
	localparam int MW = ladrc_pkg::MAG_W;
	localparam int DW = ladrc_pkg::DIV_STEPS;

	// configuration
	ladrc_pkg::word_t gain_q, beta1_q, beta2_q, beta3_q;
	logic [ladrc_pkg::H_BITS-1:0] h_q;

	// observer state and last control value
	ladrc_pkg::word_t z1_q, z2_q, z3_q, u_q;

	// sample and scratch registers
	ladrc_pkg::word_t r_q, y_q;
	ladrc_pkg::word_t e1_q, err_q, t_q, nz1_q, nz2_q, nz3_q, nu_q;

	// multiplier stage
	logic [2*W-1:0] prod_s1;
	logic           mul_neg_s1;
	logic [2:0]     mul_dst_s1;
	logic [MW-1:0]  mul_rnd;
	ladrc_pkg::word_t mul_res;

	// divider
	logic                              div_run_q;
	logic                              div_fin_q;
	logic                              div_neg_q;
	logic                              fault_q;
	logic [ladrc_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic [DW-1:0]                     div_quo_q;
	logic [W-1:0]                      div_rem_q;
	ladrc_pkg::umag_t                  div_den_q;
	logic [W:0]                        rem_sh;
	logic [W:0]                        rem_diff;
	logic                              rem_ge;

	// operands and write port
	ladrc_pkg::word_t a_val, b_val, alu_res, zero_sat;
	logic             is_alu, is_div, gain_zero;
	logic             wr_en;
	logic [2:0]       wr_dst;
	ladrc_pkg::word_t wr_val;

	// output register
	logic                 out_valid_q;
	ladrc_pkg::out_item_t out_q;

	// configuration writes, ignored beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= ladrc_pkg::RST_PLANT_GAIN;
			beta1_q <= ladrc_pkg::RST_BETA_ONE;
			beta2_q <= ladrc_pkg::RST_BETA_TWO;
			beta3_q <= ladrc_pkg::RST_BETA_THREE;
			h_q     <= ladrc_pkg::RST_SAMPLE_TIME;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ladrc_pkg::REG_PLANT_GAIN:  gain_q  <= ladrc_pkg::word_t'(cfg_data);
				ladrc_pkg::REG_BETA_ONE:    beta1_q <= ladrc_pkg::word_t'(cfg_data);
				ladrc_pkg::REG_BETA_TWO:    beta2_q <= ladrc_pkg::word_t'(cfg_data);
				ladrc_pkg::REG_BETA_THREE:  beta3_q <= ladrc_pkg::word_t'(cfg_data);
				ladrc_pkg::REG_SAMPLE_TIME: h_q     <= cfg_data[ladrc_pkg::H_BITS-1:0];
				default: ;
			endcase
		end
	end

	// operand select
	always_comb begin
		unique case (cmd.uop.a_sel)
			ladrc_pkg::SRC_Z1:   a_val = z1_q;
			ladrc_pkg::SRC_Z2:   a_val = z2_q;
			ladrc_pkg::SRC_Z3:   a_val = z3_q;
			ladrc_pkg::SRC_U:    a_val = u_q;
			ladrc_pkg::SRC_E1:   a_val = e1_q;
			ladrc_pkg::SRC_ERR:  a_val = err_q;
			ladrc_pkg::SRC_T:    a_val = t_q;
			ladrc_pkg::SRC_NZ2:  a_val = nz2_q;
			ladrc_pkg::SRC_R:    a_val = r_q;
			ladrc_pkg::SRC_Y:    a_val = y_q;
			ladrc_pkg::SRC_B1:   a_val = beta1_q;
			ladrc_pkg::SRC_B2:   a_val = beta2_q;
			ladrc_pkg::SRC_B3:   a_val = beta3_q;
			ladrc_pkg::SRC_H:    a_val = ladrc_pkg::word_t'({1'b0, h_q});
			ladrc_pkg::SRC_ZERO: a_val = '0;
			ladrc_pkg::SRC_B0:   a_val = gain_q;
			default:             a_val = '0;
		endcase
		unique case (cmd.uop.b_sel)
			ladrc_pkg::SRC_Z1:   b_val = z1_q;
			ladrc_pkg::SRC_Z2:   b_val = z2_q;
			ladrc_pkg::SRC_Z3:   b_val = z3_q;
			ladrc_pkg::SRC_U:    b_val = u_q;
			ladrc_pkg::SRC_E1:   b_val = e1_q;
			ladrc_pkg::SRC_ERR:  b_val = err_q;
			ladrc_pkg::SRC_T:    b_val = t_q;
			ladrc_pkg::SRC_NZ2:  b_val = nz2_q;
			ladrc_pkg::SRC_R:    b_val = r_q;
			ladrc_pkg::SRC_Y:    b_val = y_q;
			ladrc_pkg::SRC_B1:   b_val = beta1_q;
			ladrc_pkg::SRC_B2:   b_val = beta2_q;
			ladrc_pkg::SRC_B3:   b_val = beta3_q;
			ladrc_pkg::SRC_H:    b_val = ladrc_pkg::word_t'({1'b0, h_q});
			ladrc_pkg::SRC_ZERO: b_val = '0;
			ladrc_pkg::SRC_B0:   b_val = gain_q;
			default:             b_val = '0;
		endcase
	end

	// saturating alu and zero-gain control value
	assign is_alu    = cmd.issue && ((cmd.uop.op == ladrc_pkg::OP_ADD)
		|| (cmd.uop.op == ladrc_pkg::OP_SUB));
	assign is_div    = cmd.issue && (cmd.uop.op == ladrc_pkg::OP_DIV);
	assign gain_zero = (b_val == '0);
	assign alu_res   = ladrc_pkg::sat_addsub(a_val, b_val, cmd.uop.op == ladrc_pkg::OP_SUB);
	assign zero_sat  = a_val[W-1] ? ladrc_pkg::WORD_MIN : ladrc_pkg::WORD_MAX;

	// multiplier: 32 by 32 magnitude product, then round half away from zero and clamp
	always_ff @(posedge clk) begin
		if (cmd.issue && (cmd.uop.op == ladrc_pkg::OP_MUL)) begin
			prod_s1    <= (2*W)'(ladrc_pkg::mag(a_val)) * (2*W)'(ladrc_pkg::mag(b_val));
			mul_neg_s1 <= a_val[W-1] ^ b_val[W-1];
			mul_dst_s1 <= cmd.uop.dst;
		end
	end

	assign mul_rnd = (MW'(prod_s1) + (MW'(1) << (F - 1))) >> F;
	assign mul_res = ladrc_pkg::sat_mag(mul_rnd, mul_neg_s1);

	// restoring divider step, one quotient bit a cycle
	assign rem_sh   = {div_rem_q, div_quo_q[DW-1]};
	assign rem_ge   = (rem_sh >= {1'b0, div_den_q});
	assign rem_diff = rem_sh - {1'b0, div_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			div_fin_q <= 1'b0;
			div_cnt_q <= '0;
			fault_q   <= 1'b0;
		end else begin
			div_fin_q <= 1'b0;
			if (is_div) begin
				fault_q <= gain_zero;
				if (gain_zero) begin
					div_fin_q <= 1'b1;
				end else begin
					div_run_q <= 1'b1;
					div_cnt_q <= ladrc_pkg::DIV_CNT_W'(DW - 1);
				end
			end else if (div_run_q) begin
				if (div_cnt_q == '0) begin
					div_run_q <= 1'b0;
					div_fin_q <= 1'b1;
				end else begin
					div_cnt_q <= div_cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_div) begin
			div_neg_q <= a_val[W-1] ^ b_val[W-1];
			div_quo_q <= {ladrc_pkg::mag(a_val), {F{1'b0}}};
			div_rem_q <= '0;
			div_den_q <= ladrc_pkg::mag(b_val);
		end else if (div_run_q) begin
			div_rem_q <= rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
			div_quo_q <= {div_quo_q[DW-2:0], rem_ge};
		end
	end

	// scratch write port
	always_comb begin
		wr_en  = 1'b0;
		wr_dst = cmd.uop.dst;
		wr_val = alu_res;
		priority if (is_alu) begin
			wr_en = 1'b1;
		end else if (is_div && gain_zero) begin
			wr_en  = 1'b1;
			wr_dst = ladrc_pkg::DST_NU;
			wr_val = zero_sat;
		end else if (cmd.mul_wb) begin
			wr_en  = 1'b1;
			wr_dst = mul_dst_s1;
			wr_val = mul_res;
		end else if (div_fin_q && !fault_q) begin
			wr_en  = 1'b1;
			wr_dst = ladrc_pkg::DST_NU;
			wr_val = ladrc_pkg::sat_mag(MW'(div_quo_q), div_neg_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q <= in_data.target_value;
			y_q <= in_data.measured_value;
		end
		if (wr_en) begin
			unique case (wr_dst)
				ladrc_pkg::DST_E1:  e1_q  <= wr_val;
				ladrc_pkg::DST_ERR: err_q <= wr_val;
				ladrc_pkg::DST_T:   t_q   <= wr_val;
				ladrc_pkg::DST_NZ1: nz1_q <= wr_val;
				ladrc_pkg::DST_NZ2: nz2_q <= wr_val;
				ladrc_pkg::DST_NZ3: nz3_q <= wr_val;
				ladrc_pkg::DST_NU:  nu_q  <= wr_val;
				default: ;
			endcase
		end
	end

	// state commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z1_q <= '0;
			z2_q <= '0;
			z3_q <= '0;
			u_q  <= '0;
		end else if (cmd.commit) begin
			z1_q <= nz1_q;
			z2_q <= nz2_q;
			z3_q <= nz3_q;
			u_q  <= nu_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.control_value        <= nu_q;
			out_q.tracking_error       <= err_q;
			out_q.position_estimate    <= nz1_q;
			out_q.rate_estimate        <= nz2_q;
			out_q.disturbance_estimate <= nz3_q;
			out_q.divide_fault         <= fault_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign status.div_done = div_fin_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

// ===== rtl/linear_adrc_controller.sv =====
// top level of the linear adrc controller: sequencer plus datapath
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+--------------------------
//  in       | in_valid, in_ready, in_data     | ladrc_pkg::in_item_t
//  out      | out_valid, out_ready, out_data  | ladrc_pkg::out_item_t
//  config   | cfg_we, cfg_index, cfg_data     | 32 bit register write
//
// one sample beat at a time; with a nonzero plant gain a sample runs through the 18 program
// steps with a writeback after each of the 7 multiplies, then the 48 step divider, a finish
// step and the commit; a zero plant gain skips the divider steps.
// in_ready is high only while the sequencer is idle, which it enters as the result is
// loaded, so the next sample is accepted even while the result waits at the output.
// a stalled output holds the sequencer at its final step; reset clears the state.
`default_nettype none
module linear_adrc_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ladrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ladrc_pkg::WORD_BITS-1:0] cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire ladrc_pkg::in_item_t             in_data,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output ladrc_pkg::out_item_t                 out_data
);

	ladrc_pkg::cmd_t    cmd;
	ladrc_pkg::status_t status;

	// sequencer
	ladrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// arithmetic and state
	ladrc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== verif/linear_adrc_controller_tb.sv =====
// self-checking testbench of the linear adrc controller with a bit-exact controller predictor
module linear_adrc_controller_tb;
	import ladrc_pkg::*;

	localparam int SAMPLE_TARGET = 1500;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int MAX_WAIT      = 18;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_SAMPLE_TIME + 1'b1;
	localparam word_t CORNERS [5] = '{WORD_MAX, WORD_MIN, 32'sd0, 32'sd1, -32'sd1};

	typedef enum {
		SET_DEFAULT, SET_MODERATE, SET_SIGNED, SET_WILD, SET_NO_GAIN, SET_CORNERS
	} setting_kind_e;

	// predicted controller state and the queue of results still owed by the block
	class control_tracker;
		word_t gain, beta_one, beta_two, beta_three;
		logic [H_BITS-1:0] period;
		word_t z_pos, z_rate, z_dist, u_prev;
		out_item_t expected_results[$];
		int mismatches;
		int faults_seen;

		function new();
			gain       = RST_PLANT_GAIN;
			beta_one   = RST_BETA_ONE;
			beta_two   = RST_BETA_TWO;
			beta_three = RST_BETA_THREE;
			period     = RST_SAMPLE_TIME;
			z_pos      = '0;
			z_rate     = '0;
			z_dist     = '0;
			u_prev     = '0;
			mismatches  = 0;
			faults_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_BITS-1:0] val);
			case (idx)
				REG_PLANT_GAIN:  gain = val;
				REG_BETA_ONE:    beta_one = val;
				REG_BETA_TWO:    beta_two = val;
				REG_BETA_THREE:  beta_three = val;
				REG_SAMPLE_TIME: period = val[H_BITS-1:0];
				default: ;
			endcase
		endfunction

		function word_t clip(longint v);
			if (v > longint'(WORD_MAX)) return WORD_MAX;
			if (v < longint'(WORD_MIN)) return WORD_MIN;
			return word_t'(v);
		endfunction

		function word_t sum_clip(word_t a, word_t b);
			return clip(longint'(a) + longint'(b));
		endfunction

		function word_t diff_clip(word_t a, word_t b);
			return clip(longint'(a) - longint'(b));
		endfunction

		function longint unsigned abs_wide(word_t a);
			longint w;
			w = longint'(a);
			return unsigned'(w < 0 ? -w : w);
		endfunction

		// q16.16 product, rounded half away from zero
		function word_t qmul(word_t a, word_t b);
			longint unsigned p;
			longint v;
			p = (abs_wide(a) * abs_wide(b) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			v = longint'(p);
			return clip((a[WORD_BITS-1] ^ b[WORD_BITS-1]) ? -v : v);
		endfunction

		// q16.16 quotient, truncated toward zero, divisor nonzero
		function word_t qdiv(word_t n, word_t d);
			longint unsigned q;
			longint v;
			q = (abs_wide(n) << FRAC_BITS) / abs_wide(d);
			v = longint'(q);
			return clip((n[WORD_BITS-1] ^ d[WORD_BITS-1]) ? -v : v);
		endfunction

		// observer step from the old states, then error and control law
		function void take_sample(in_item_t s);
			word_t h_w, e1, n_pos, n_rate, n_dist, err, num, u_new;
			out_item_t res;
			h_w    = word_t'({1'b0, period});
			e1     = diff_clip(z_pos, s.measured_value);
			n_pos  = sum_clip(z_pos, qmul(h_w, diff_clip(z_rate, qmul(beta_one, e1))));
			n_rate = sum_clip(z_rate, qmul(h_w,
				sum_clip(diff_clip(z_dist, qmul(beta_two, e1)), u_prev)));
			n_dist = sum_clip(z_dist, qmul(h_w, diff_clip('0, qmul(beta_three, e1))));
			err    = diff_clip(s.target_value, s.measured_value);
			num    = diff_clip(qmul(beta_one, err), n_rate);
			// zero plant gain: saturate by the sign of the numerator
			if (gain == 0) u_new = (num < 0) ? WORD_MIN : WORD_MAX;
			else u_new = qdiv(num, gain);
			z_pos  = n_pos;
			z_rate = n_rate;
			z_dist = n_dist;
			u_prev = u_new;
			res.control_value        = u_new;
			res.tracking_error       = err;
			res.position_estimate    = n_pos;
			res.rate_estimate        = n_rate;
			res.disturbance_estimate = n_dist;
			res.divide_fault         = (gain == 0);
			expected_results.push_back(res);
		endfunction

		function void match_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				$error("result beat with no sample pending");
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			if (got.control_value !== want.control_value) begin
				$error("control_value: expected %0d, got %0d",
					want.control_value, got.control_value);
				mismatches++;
			end
			if (got.tracking_error !== want.tracking_error) begin
				$error("tracking_error: expected %0d, got %0d",
					want.tracking_error, got.tracking_error);
				mismatches++;
			end
			if (got.position_estimate !== want.position_estimate) begin
				$error("position_estimate: expected %0d, got %0d",
					want.position_estimate, got.position_estimate);
				mismatches++;
			end
			if (got.rate_estimate !== want.rate_estimate) begin
				$error("rate_estimate: expected %0d, got %0d",
					want.rate_estimate, got.rate_estimate);
				mismatches++;
			end
			if (got.disturbance_estimate !== want.disturbance_estimate) begin
				$error("disturbance_estimate: expected %0d, got %0d",
					want.disturbance_estimate, got.disturbance_estimate);
				mismatches++;
			end
			if (got.divide_fault !== want.divide_fault) begin
				$error("divide_fault: expected %0d, got %0d",
					want.divide_fault, got.divide_fault);
				mismatches++;
			end
			if (got.divide_fault === 1'b1) faults_seen++;
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WORD_BITS-1:0] cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;

	control_tracker tracker;
	bit calm = 1'b0;
	int samples_sent = 0;
	int settings_used = 0;
	int cycle_count = 0;

	linear_adrc_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic word_t small_signed(int span);
		return word_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic word_t corner_word();
		return CORNERS[$urandom_range(0, 4)];
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		tracker.write_reg(idx, val);
	endtask

	// one full register setting, optionally with writes to the unused indexes
	task automatic program_settings(word_t g, word_t b1, word_t b2, word_t b3,
			logic [WORD_BITS-1:0] hp, bit spare);
		if (spare) begin
			for (int i = int'(REG_SPARE_FIRST); i < (1 << CFG_IDX_W); i++)
				write_reg(CFG_IDX_W'(i), $urandom());
		end
		write_reg(REG_PLANT_GAIN, g);
		write_reg(REG_BETA_ONE, b1);
		write_reg(REG_BETA_TWO, b2);
		write_reg(REG_BETA_THREE, b3);
		write_reg(REG_SAMPLE_TIME, hp);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// one sample beat after a random gap
	task automatic send_sample(word_t r, word_t y);
		in_item_t s;
		int gap;
		s.target_value   = r;
		s.measured_value = y;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.take_sample(s);
		samples_sent++;
	endtask

	// hold the sender until every owed result is back and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (tracker.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// tracking-like and shifted wide samples, some full-width, a few at the corners
	task automatic draw_sample(output word_t r, output word_t y);
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 4) begin
			r = small_signed(16 * 65536);
			y = r + small_signed(65536);
		end else if (mode < 8) begin
			r = word_t'($urandom()) >>> 4;
			y = word_t'($urandom()) >>> 4;
		end else if (mode < 9) begin
			r = word_t'($urandom());
			y = word_t'($urandom());
		end else begin
			r = corner_word();
			y = corner_word();
		end
	endtask

	task automatic pick_setting();
		setting_kind_e kind;
		word_t g, b1, b2, b3;
		logic [WORD_BITS-1:0] hp;
		kind = setting_kind_e'($urandom_range(0, 5));
		g  = RST_PLANT_GAIN;
		b1 = RST_BETA_ONE;
		b2 = RST_BETA_TWO;
		b3 = RST_BETA_THREE;
		hp = WORD_BITS'(RST_SAMPLE_TIME);
		case (kind)
			SET_DEFAULT: ;
			SET_MODERATE, SET_NO_GAIN: begin
				g  = (kind == SET_NO_GAIN) ? word_t'(0) : small_signed(4 * 65536);
				b1 = word_t'($urandom_range(0, 8 * 65536));
				b2 = word_t'($urandom_range(0, 8 * 65536));
				b3 = word_t'($urandom_range(0, 8 * 65536));
				hp = $urandom_range(0, 6554);
			end
			SET_SIGNED: begin
				g  = small_signed(4 * 65536);
				b1 = small_signed(8 * 65536);
				b2 = small_signed(8 * 65536);
				b3 = small_signed(8 * 65536);
				hp = $urandom_range(0, 65536);
			end
			SET_WILD: begin
				g  = $urandom();
				b1 = $urandom();
				b2 = $urandom();
				b3 = $urandom();
				hp = $urandom();
			end
			SET_CORNERS: begin
				g  = corner_word();
				b1 = corner_word();
				b2 = corner_word();
				b3 = corner_word();
				hp = corner_word();
			end
			default: ;
		endcase
		program_settings(g, b1, b2, b3, hp, $urandom_range(0, 3) == 0);
	endtask

	// result side: random stalls, every accepted beat checked
	initial begin
		int stall;
		repeat (3) @(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			tracker.match_result(out_data);
		end
	end

	// reset, directed corners, then random phases
	initial begin
		int stop;
		int count;
		word_t r, y;
		tracker = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero plant gain from the cleared state: zero numerator, then both signs
		program_settings('0, RST_BETA_ONE, RST_BETA_TWO, RST_BETA_THREE,
			WORD_BITS'(RST_SAMPLE_TIME), 1'b1);
		send_sample('0, '0);
		send_sample('0, 32'sd65536);
		send_sample(WORD_MIN, WORD_MAX);
		send_sample(WORD_MAX, WORD_MIN);
		wait_idle();

		// default gains, period written with its unused top bit set
		program_settings(RST_PLANT_GAIN, RST_BETA_ONE, RST_BETA_TWO, RST_BETA_THREE,
			32'hFFFF_FFFF, 1'b1);
		send_sample(WORD_MAX, WORD_MIN);
		send_sample(WORD_MIN, WORD_MAX);
		send_sample(WORD_MAX, WORD_MAX);
		send_sample(WORD_MIN, WORD_MIN);
		send_sample('0, '0);
		wait_idle();

		// most negative gains, zero period
		program_settings(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0, 1'b0);
		send_sample(WORD_MAX, WORD_MIN);
		send_sample(WORD_MIN, WORD_MAX);
		send_sample('0, WORD_MAX);
		send_sample(WORD_MIN, '0);
		wait_idle();

		// most positive gains, longest period
		program_settings(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 32'h7FFF_FFFF, 1'b0);
		send_sample(WORD_MAX, WORD_MIN);
		send_sample(WORD_MIN, WORD_MAX);
		send_sample(-32'sd1, 32'sd1);
		send_sample(32'sd65536, '0);
		wait_idle();

		// tiniest negative plant gain drives the quotient into saturation
		program_settings(-32'sd1, RST_BETA_ONE, RST_BETA_TWO, RST_BETA_THREE,
			WORD_BITS'(RST_SAMPLE_TIME), 1'b0);
		send_sample(32'sd65536, '0);
		send_sample(-32'sd65536, 32'sd65536);
		wait_idle();

		stop = samples_sent + SAMPLE_TARGET;
		while (samples_sent < stop) begin
			calm = ($urandom_range(0, 4) == 0);
			pick_setting();
			count = $urandom_range(40, 160);
			repeat (count) begin
				draw_sample(r, y);
				send_sample(r, y);
			end
			wait_idle();
		end

		if (tracker.expected_results.size() != 0) begin
			$error("%0d results never arrived", tracker.expected_results.size());
			tracker.mismatches++;
		end
		$display("run covered %0d samples over %0d register settings, %0d with divide fault",
			samples_sent, settings_used, tracker.faults_seen);
		if (tracker.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
